FILE: rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int HUE_TURN   = 360;
  localparam int HUE_SECTOR = 60;
  localparam int FULL_LEVEL = 255;

  // Bias that lifts any 16-bit signed hue above zero, a whole number of turns
  localparam logic signed [16:0] HUE_BIAS = 17'(HUE_TURN * 92);

  // floor(u / 360) == (u * HUE_RECIP) >> HUE_SHIFT for all u < 2^17
  localparam int HUE_SHIFT = 25;
  localparam logic [16:0] HUE_RECIP = 17'(((2 ** HUE_SHIFT) + HUE_TURN - 1) / HUE_TURN);

  // floor(x / 15300) == (x * CH_RECIP) >> CH_SHIFT for all x <= 60 * 255 * 255
  localparam int CH_DIV   = HUE_SECTOR * FULL_LEVEL;
  localparam int CH_SHIFT = 36;
  localparam logic [22:0] CH_RECIP =
    23'(((longint'(1) << CH_SHIFT) + longint'(CH_DIV) - 1) / longint'(CH_DIV));

  localparam int HW = 9;   // reduced hue, 0..359
  localparam int CW = 16;  // chroma s*v
  localparam int NW = 22;  // scaled components, up to 60*255*255
  localparam int FW = 6;   // offset within a sector

  typedef enum logic [2:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HW-1:0] h;
    logic [CW-1:0] c;
    logic [NW-1:0] cn;
    logic [NW-1:0] mn;
  } wrap_t;

  typedef struct packed {
    logic [NW-1:0] r;
    logic [NW-1:0] g;
    logic [NW-1:0] b;
  } sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

FILE: rtl/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter.
// Input stream s_*: one pixel per transfer, s_tdata carries hue (signed degrees,
// any value, wrapped modulo 360), saturation and value (fractions of 255).
// Output stream m_*: one RGB pixel per input pixel, in input order, 8 bits per
// channel, each channel floor(fraction * 255).
// Pipeline of five register stages: hue bias and reciprocal multiply, hue
// remainder and component scaling, sector decode, sector multiply and channel
// placement, divide-by-15300 reciprocal multiply into the output register.
// Throughput is one pixel per cycle while the receiver keeps m_tready high.
// Each stage has its own valid bit and advances when empty or when the stage
// after it advances, so bubbles close up while the receiver stalls; a stalled
// output holds m_tdata steady, and s_tready falls only once all stages are full.
// Reset (rst, synchronous) empties every stage; no pixel is held across reset.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // hue_degrees[15:0], saturation_level[23:16], value_level[31:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);
  import hsv2rgb_pkg::*;

  logic  wrap_valid, wrap_ready, sum_valid, sum_ready;
  wrap_t wrap_data;
  sum_t  sum_data;
  rgb_t  rgb;

  hsv2rgb_hue_wrap u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .hue       (signed'(s_tdata[15:0])),
    .sat       (s_tdata[23:16]),
    .val       (s_tdata[31:24]),
    .out_valid (wrap_valid),
    .out_ready (wrap_ready),
    .out_data  (wrap_data)
  );

  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wrap_valid),
    .in_ready  (wrap_ready),
    .in_data   (wrap_data),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_data)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (rgb)
  );

  assign m_tdata = {rgb.b, rgb.g, rgb.r};

endmodule

FILE: rtl/hsv2rgb_hue_wrap.sv
module hsv2rgb_hue_wrap (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   hue,
  input  logic [7:0]           sat,
  input  logic [7:0]           val,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsv2rgb_pkg::wrap_t   out_data
);
  import hsv2rgb_pkg::*;

  logic              v1, v2, en1, en2;
  logic [16:0]       u1, u_next;
  logic [7:0]        q1, q_next;
  logic [CW-1:0]     c1, c_next;
  logic [7:0]        val1;
  logic signed [16:0] hue_ext;
  logic [33:0]       quot_prod;
  wrap_t             w2, w2_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign hue_ext   = 17'(hue);
  assign u_next    = unsigned'(hue_ext + HUE_BIAS);
  assign quot_prod = 34'(u_next) * 34'(HUE_RECIP);
  assign q_next    = 8'(quot_prod >> HUE_SHIFT);
  assign c_next    = CW'(sat) * CW'(val);

  always_comb begin
    w2_next.h  = HW'(u1 - 17'(q1) * 17'(HUE_TURN));
    w2_next.c  = c1;
    w2_next.cn = NW'(c1) * NW'(HUE_SECTOR);
    w2_next.mn = NW'(HUE_SECTOR) * (NW'(val1) * NW'(FULL_LEVEL) - NW'(c1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1 && in_valid) begin
      u1   <= u_next;
      q1   <= q_next;
      c1   <= c_next;
      val1 <= val;
    end
    if (en2 && v1) begin
      w2 <= w2_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = w2;

endmodule

FILE: rtl/hsv2rgb_sector.sv
module hsv2rgb_sector (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsv2rgb_pkg::wrap_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsv2rgb_pkg::sum_t    out_data
);
  import hsv2rgb_pkg::*;

  logic          v3, v4, en3, en4;
  sector_t       sec3, sec_next;
  logic [FW-1:0] frac3, frac_next;
  logic [CW-1:0] c3;
  logic [NW-1:0] cn3, mn3;
  logic [HW-1:0] sec_base;
  logic [FW-1:0] factor;
  logic [NW-1:0] xn;
  sum_t          s4, s4_next;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  always_comb begin
    if (in_data.h >= HW'(5 * HUE_SECTOR)) begin
      sec_next = SECT_M_TO_R;
    end else if (in_data.h >= HW'(4 * HUE_SECTOR)) begin
      sec_next = SECT_B_TO_M;
    end else if (in_data.h >= HW'(3 * HUE_SECTOR)) begin
      sec_next = SECT_C_TO_B;
    end else if (in_data.h >= HW'(2 * HUE_SECTOR)) begin
      sec_next = SECT_G_TO_C;
    end else if (in_data.h >= HW'(HUE_SECTOR)) begin
      sec_next = SECT_Y_TO_G;
    end else begin
      sec_next = SECT_R_TO_Y;
    end
  end

  assign sec_base  = HW'(sec_next) * HW'(HUE_SECTOR);
  assign frac_next = FW'(in_data.h - sec_base);

  // odd sectors ramp down, even ones ramp up
  assign factor = sec3[0] ? FW'(HUE_SECTOR - int'(frac3)) : frac3;
  assign xn     = NW'(c3) * NW'(factor);

  always_comb begin
    case (sec3)
      SECT_R_TO_Y: begin s4_next.r = cn3 + mn3; s4_next.g = xn + mn3;  s4_next.b = mn3; end
      SECT_Y_TO_G: begin s4_next.r = xn + mn3;  s4_next.g = cn3 + mn3; s4_next.b = mn3; end
      SECT_G_TO_C: begin s4_next.r = mn3; s4_next.g = cn3 + mn3; s4_next.b = xn + mn3;  end
      SECT_C_TO_B: begin s4_next.r = mn3; s4_next.g = xn + mn3;  s4_next.b = cn3 + mn3; end
      SECT_B_TO_M: begin s4_next.r = xn + mn3;  s4_next.g = mn3; s4_next.b = cn3 + mn3; end
      default:     begin s4_next.r = cn3 + mn3; s4_next.g = mn3; s4_next.b = xn + mn3;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
    end
    if (en3 && in_valid) begin
      sec3  <= sec_next;
      frac3 <= frac_next;
      c3    <= in_data.c;
      cn3   <= in_data.cn;
      mn3   <= in_data.mn;
    end
    if (en4 && v3) begin
      s4 <= s4_next;
    end
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule

FILE: rtl/hsv2rgb_scale.sv
module hsv2rgb_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsv2rgb_pkg::sum_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsv2rgb_pkg::rgb_t    out_data
);
  import hsv2rgb_pkg::*;

  logic        v5, en5;
  logic [44:0] prod_r, prod_g, prod_b;
  rgb_t        rgb5, rgb_next;

  assign en5      = !v5 || out_ready;
  assign in_ready = en5;

  // divide by 60*255 through a rounded-up reciprocal, exact over the input range
  assign prod_r = 45'(in_data.r) * 45'(CH_RECIP);
  assign prod_g = 45'(in_data.g) * 45'(CH_RECIP);
  assign prod_b = 45'(in_data.b) * 45'(CH_RECIP);

  assign rgb_next.r = 8'(prod_r >> CH_SHIFT);
  assign rgb_next.g = 8'(prod_g >> CH_SHIFT);
  assign rgb_next.b = 8'(prod_b >> CH_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= in_valid;
    end
    if (en5 && in_valid) begin
      rgb5 <= rgb_next;
    end
  end

  assign out_valid = v5;
  assign out_data  = rgb5;

endmodule

FILE: rtl/hsv2rgb_checker.sv
module hsv2rgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output stage always frees the input side
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // with the receiver ready while a pixel passes through the stages, it reaches m_tvalid without stalling
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
      |=> m_tvalid)
    else $error("pixel did not arrive after five cycles");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output changed");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
